// ===== hdl/ctbf_pkg.sv =====
// package for the contour turn break finder
// holds shared widths, register codes, sequencer states and the exp2 root constants
// no dependencies
package ctbf_pkg;

  localparam int MAX_HALF_DEF = 16;
  localparam int MAX_POINTS   = 4096;
  localparam int IDX_W        = 12;
  localparam int COORD_W      = 16;
  localparam int SCORE_W      = 16;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 16;

  localparam logic [SCORE_W-1:0] SCORE_ONE = 16'hFFFF;
  localparam logic [SCORE_W:0]   MIN_INIT  = 17'h10000;
  localparam logic [16:0]        LOG2E_Q16 = 17'd94548;
  localparam logic [30:0]        EXP_ONE   = 31'h4000_0000;

  typedef enum logic [2:0] {
    REG_WINDOW_HALF,
    REG_WEIGHT_CONST,
    REG_MEAN_CONST,
    REG_WEIGHT_TURN,
    REG_MEAN_TURN,
    REG_BREAK_THRESHOLD
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECIDE,
    S_RD_PREV,
    S_RD_CUR,
    S_RD_DONE,
    S_MUL,
    S_NORM_CHK,
    S_SQRT_A,
    S_SQRT_B,
    S_DIV_Q,
    S_DIV_C,
    S_ZMUL,
    S_ZCHK,
    S_UMUL,
    S_EXP,
    S_VSHIFT,
    S_DIV_S,
    S_EMIT_MAIN,
    S_TAIL_START,
    S_EMIT_TAIL,
    S_FINISH
  } state_t;

  typedef logic [30:0] root_tab_t [16];

  // floor square root, one result bit per pass, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      b = 64'd1 << (2 * i);
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  // repeated square roots of one half in Q.30
  function automatic root_tab_t make_roots();
    root_tab_t   t;
    logic [63:0] root;
    root = isqrt64(64'd1 << 59);
    for (int j = 0; j < 16; j++) begin
      t[j] = root[30:0];
      root = isqrt64(root << 30);
    end
    return t;
  endfunction

  localparam root_tab_t EXP_ROOT = make_roots();

endpackage

// ===== hdl/ctbf_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
module ctbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 33
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/contour_turn_break_finder_core.sv =====
// contour turn break finder, top level
// depends on ctbf_pkg and ctbf_ram
//
// Points of one contour chain come in one transaction each; the block scores the point
// window_half places back with a logistic turn score, gives ends a score of 1.0 and on the
// last point of the chain flushes the remaining end scores, the last of them carrying the
// break decision at the midpoint of the run of minimum scores. For a point that
// completes an interior window, one compare-subtract unit, used one bit per cycle, does
// both vector lengths and three divisions, and one multiplier does the dot products, the
// logistic sum and 16 steps of the exp2 product. The end scores of the last point are
// flushed one by one, as the result register is refilled only after its transaction has
// been taken. The block takes no new point while one is being worked on, and a result
// still waiting for the receiver holds it until the receiver takes it.
module contour_turn_break_finder_core
  import ctbf_pkg::*;
#(
  parameter int MAX_HALF = MAX_HALF_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [COORD_W-1:0]    point_x,
  input  logic [COORD_W-1:0]    point_y,
  input  logic                  chain_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [IDX_W-1:0]      point_index,
  output logic [SCORE_W-1:0]    break_score,
  output logic                  degenerate,
  output logic                  run_last,
  output logic                  break_found,
  output logic [IDX_W-1:0]      break_index,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH = 2 * MAX_HALF + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int HW    = $clog2(MAX_HALF + 1);
  localparam int SW    = $clog2(DEPTH + 1);
  localparam int CW    = AW + 1;

  // configuration
  logic [4:0]         window_half;
  logic signed [15:0] weight_const;
  logic signed [15:0] mean_const;
  logic signed [15:0] weight_turn;
  logic signed [15:0] mean_turn;
  logic [15:0]        break_threshold;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_half     <= 5'd4;
      weight_const    <= '0;
      mean_const      <= '0;
      weight_turn     <= '0;
      mean_turn       <= '0;
      break_threshold <= 16'h8000;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_WINDOW_HALF:     window_half     <= cfg_data[4:0];
        REG_WEIGHT_CONST:    weight_const    <= cfg_data;
        REG_MEAN_CONST:      mean_const      <= cfg_data;
        REG_WEIGHT_TURN:     weight_turn     <= cfg_data;
        REG_MEAN_TURN:       mean_turn       <= cfg_data;
        REG_BREAK_THRESHOLD: break_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  state_t state, state_next;

  // chain state
  logic [SW-1:0]      seen;
  logic [AW-1:0]      wr_ptr;
  logic [IDX_W-1:0]   point_count;
  logic [HW-1:0]      cur_half;
  logic [SCORE_W:0]   min_score;
  logic [IDX_W-1:0]   min_first;
  logic [IDX_W-1:0]   min_last;

  // item payload and working registers
  logic [COORD_W-1:0] x_in, y_in, pp_x, pp_y;
  logic               last_r;
  logic signed [16:0] ax, ay, bx, by;
  logic [33:0]        na, nb;
  logic signed [33:0] dot;
  logic signed [65:0] prod;
  logic [2:0]         mcnt;
  logic [32:0]        acc;
  logic [31:0]        quo;
  logic [53:0]        src;
  logic [31:0]        dvs;
  logic [4:0]         itc;
  logic [26:0]        sb;
  logic signed [13:0] cosv;
  logic signed [34:0] z;
  logic               zneg;
  logic [20:0]        u;
  logic [30:0]        v;
  logic [3:0]         jcnt;
  logic [SCORE_W-1:0] main_score;
  logic               main_deg;
  logic [HW-1:0]      dcnt;

  // ring of recent points
  logic              ram_we;
  logic [AW-1:0]     raddr;
  logic [31:0]       rdata;

  ctbf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr),
    .wdata ({point_x, point_y}),
    .raddr (raddr),
    .rdata (rdata)
  );

  logic          seen_ge_r, seen_ge_2r;
  logic [HW:0]   rd_k;
  logic [CW-1:0] rd_sum;
  logic [HW-1:0] half_clip;

  assign seen_ge_r  = int'(seen) >= int'(cur_half);
  assign seen_ge_2r = int'(seen) >= 2 * int'(cur_half);

  always_comb begin
    rd_k   = (state == S_RD_PREV) ? {cur_half, 1'b0} : {1'b0, cur_half};
    rd_sum = {1'b0, wr_ptr} + CW'(DEPTH) - CW'(rd_k);
    raddr  = (rd_sum >= CW'(DEPTH)) ? AW'(rd_sum - CW'(DEPTH)) : AW'(rd_sum);
  end

  always_comb begin
    if (window_half == 5'd0) begin
      half_clip = HW'(1);
    end else if (int'(window_half) > MAX_HALF) begin
      half_clip = HW'(MAX_HALF);
    end else begin
      half_clip = HW'(window_half);
    end
  end

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [17:0] cterm, tterm;
  logic [30:0]        root_sel;
  logic [15:0]        frac;

  assign frac     = u[15:0];
  assign root_sel = frac[4'hF - jcnt] ? EXP_ROOT[jcnt] : EXP_ONE;
  assign cterm    = 18'sd4096 - 18'(mean_const);
  assign tterm    = 18'(cosv) - 18'(mean_turn);

  logic signed [34:0] zabs;
  logic [26:0]        zm;
  logic               zbig;

  assign zabs = z[34] ? -z : z;
  assign zm   = zabs[34:8];
  assign zbig = |zm[26:20];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        case (mcnt)
          3'd0: begin mul_a = 33'(ax); mul_b = 33'(ax); end
          3'd1: begin mul_a = 33'(ay); mul_b = 33'(ay); end
          3'd2: begin mul_a = 33'(bx); mul_b = 33'(bx); end
          3'd3: begin mul_a = 33'(by); mul_b = 33'(by); end
          3'd4: begin mul_a = 33'(ax); mul_b = 33'(bx); end
          3'd5: begin mul_a = 33'(ay); mul_b = 33'(by); end
          default: ;
        endcase
      end
      S_ZMUL: begin
        if (mcnt == 3'd0) begin
          mul_a = 33'(cterm);
          mul_b = 33'(weight_const);
        end else begin
          mul_a = 33'(tterm);
          mul_b = 33'(weight_turn);
        end
      end
      S_UMUL: begin
        mul_a = $signed({13'b0, zm[19:0]});
        mul_b = $signed({16'b0, LOG2E_Q16});
      end
      S_EXP: begin
        mul_a = $signed({2'b0, v});
        mul_b = $signed({2'b0, root_sel});
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // shared compare-subtract unit: one root bit or one quotient bit per cycle
  logic        sq_mode;
  logic [34:0] cand, sub;
  logic [35:0] diff;
  logic        ge;
  logic [32:0] acc_step;
  logic [31:0] quo_step;
  logic [53:0] src_step;

  always_comb begin
    sq_mode  = (state == S_SQRT_A) || (state == S_SQRT_B);
    cand     = sq_mode ? {acc, src[53:52]} : {1'b0, acc, src[53]};
    sub      = sq_mode ? {1'b0, quo, 2'b01} : {3'b0, dvs};
    diff     = {1'b0, cand} - {1'b0, sub};
    ge       = !diff[35];
    acc_step = ge ? diff[32:0] : cand[32:0];
    quo_step = {quo[30:0], ge};
    src_step = sq_mode ? {src[51:0], 2'b00} : {src[52:0], 1'b0};
  end

  logic        dot_neg;
  logic [33:0] mag;
  logic [13:0] cmag;
  logic [30:0] vs;

  assign dot_neg = dot[33];
  assign mag     = dot_neg ? 34'(-dot) : 34'(dot);
  assign cmag    = (quo_step[13:0] > 14'd4096) ? 14'd4096 : quo_step[13:0];
  assign vs      = v >> u[20:16];

  // result selection and minimum tracking
  logic             out_load;
  logic [IDX_W-1:0] emit_idx;
  logic [SCORE_W-1:0] emit_score;
  logic             emit_deg;
  logic             emit_last;
  logic [SCORE_W:0] min_score_next;
  logic [IDX_W-1:0] min_first_next, min_last_next;
  logic [IDX_W:0]   mid_sum;
  logic             brk_found;

  always_comb begin
    in_ready   = (state == S_IDLE);
    ram_we     = in_valid && (state == S_IDLE);
    out_load   = 1'b0;
    emit_idx   = point_count - IDX_W'(cur_half);
    emit_score = main_score;
    emit_deg   = main_deg;
    emit_last  = 1'b0;
    case (state)
      S_EMIT_MAIN: out_load = !out_valid;
      S_EMIT_TAIL: begin
        out_load   = !out_valid;
        emit_idx   = point_count - IDX_W'(dcnt);
        emit_score = SCORE_ONE;
        emit_deg   = 1'b0;
        emit_last  = (dcnt == '0);
      end
      default: ;
    endcase
  end

  always_comb begin
    min_score_next = min_score;
    min_first_next = min_first;
    min_last_next  = min_last;
    if (out_load && !emit_deg) begin
      if ({1'b0, emit_score} < min_score) begin
        min_score_next = {1'b0, emit_score};
        min_first_next = emit_idx;
        min_last_next  = emit_idx;
      end else if ({1'b0, emit_score} == min_score) begin
        min_last_next = emit_idx;
      end
    end
    mid_sum   = {1'b0, min_first_next} + {1'b0, min_last_next} + (IDX_W+1)'(1);
    brk_found = min_score_next < {1'b0, break_threshold};
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:       if (in_valid) state_next = S_DECIDE;
      S_DECIDE: begin
        if (seen_ge_2r) state_next = S_RD_PREV;
        else if (seen_ge_r) state_next = S_EMIT_MAIN;
        else state_next = S_TAIL_START;
      end
      S_RD_PREV:    state_next = S_RD_CUR;
      S_RD_CUR:     state_next = S_RD_DONE;
      S_RD_DONE:    state_next = S_MUL;
      S_MUL:        if (mcnt == 3'd6) state_next = S_NORM_CHK;
      S_NORM_CHK:   state_next = (na == '0 || nb == '0) ? S_EMIT_MAIN : S_SQRT_A;
      S_SQRT_A:     if (itc == '0) state_next = S_SQRT_B;
      S_SQRT_B:     if (itc == '0) state_next = S_DIV_Q;
      S_DIV_Q:      if (itc == '0) state_next = S_DIV_C;
      S_DIV_C:      if (itc == '0) state_next = S_ZMUL;
      S_ZMUL:       if (mcnt == 3'd2) state_next = S_ZCHK;
      S_ZCHK:       state_next = zbig ? S_EMIT_MAIN : S_UMUL;
      S_UMUL:       state_next = S_EXP;
      S_EXP:        if (jcnt == 4'hF) state_next = S_VSHIFT;
      S_VSHIFT:     state_next = S_DIV_S;
      S_DIV_S:      if (itc == '0) state_next = S_EMIT_MAIN;
      S_EMIT_MAIN:  if (!out_valid) state_next = S_TAIL_START;
      S_TAIL_START: state_next = last_r ? S_EMIT_TAIL : S_FINISH;
      S_EMIT_TAIL:  if (!out_valid && dcnt == '0) state_next = S_FINISH;
      S_FINISH:     state_next = S_IDLE;
      default:      state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      seen        <= '0;
      wr_ptr      <= '0;
      point_count <= '0;
      cur_half    <= HW'(1);
      min_score   <= MIN_INIT;
      min_first   <= '0;
      min_last    <= '0;
      out_valid   <= 1'b0;
    end else begin
      state     <= state_next;
      min_score <= min_score_next;
      min_first <= min_first_next;
      min_last  <= min_last_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_valid && seen == '0) begin
        cur_half <= half_clip;
      end
      if (state == S_FINISH) begin
        if (last_r) begin
          seen        <= '0;
          wr_ptr      <= '0;
          point_count <= '0;
          min_score   <= MIN_INIT;
          min_first   <= '0;
          min_last    <= '0;
        end else begin
          point_count <= point_count + 1'b1;
          if (seen != SW'(DEPTH)) seen <= seen + 1'b1;
          wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      point_index <= emit_idx;
      break_score <= emit_score;
      degenerate  <= emit_deg;
      run_last    <= emit_last;
      break_found <= emit_last && brk_found;
      break_index <= (emit_last && brk_found) ? mid_sum[IDX_W:1] : '0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          x_in   <= point_x;
          y_in   <= point_y;
          last_r <= chain_end;
        end
      end
      S_DECIDE: begin
        main_score <= SCORE_ONE;
        main_deg   <= 1'b0;
        mcnt       <= '0;
      end
      S_RD_CUR: begin
        pp_x <= rdata[31:16];
        pp_y <= rdata[15:0];
      end
      S_RD_DONE: begin
        ax <= $signed({1'b0, rdata[31:16]}) - $signed({1'b0, pp_x});
        ay <= $signed({1'b0, rdata[15:0]}) - $signed({1'b0, pp_y});
        bx <= $signed({1'b0, x_in}) - $signed({1'b0, rdata[31:16]});
        by <= $signed({1'b0, y_in}) - $signed({1'b0, rdata[15:0]});
      end
      S_MUL: begin
        prod <= mul_p;
        mcnt <= mcnt + 1'b1;
        case (mcnt)
          3'd1: na  <= prod[33:0];
          3'd2: na  <= na + prod[33:0];
          3'd3: nb  <= prod[33:0];
          3'd4: nb  <= nb + prod[33:0];
          3'd5: dot <= prod[33:0];
          3'd6: dot <= dot + prod[33:0];
          default: ;
        endcase
      end
      S_NORM_CHK: begin
        main_score <= '0;
        main_deg   <= 1'b1;
        acc        <= '0;
        quo        <= '0;
        src        <= {na, 20'b0};
        itc        <= 5'd26;
      end
      S_SQRT_A: begin
        if (itc == '0) begin
          dvs <= {5'b0, quo_step[26:0]};
          acc <= '0;
          quo <= '0;
          src <= {nb, 20'b0};
          itc <= 5'd26;
        end else begin
          acc <= acc_step;
          quo <= quo_step;
          src <= src_step;
          itc <= itc - 1'b1;
        end
      end
      S_SQRT_B: begin
        if (itc == '0) begin
          sb  <= quo_step[26:0];
          acc <= 33'(mag[33:8]);
          quo <= '0;
          src <= {mag[7:0], 46'b0};
          itc <= 5'd29;
        end else begin
          acc <= acc_step;
          quo <= quo_step;
          src <= src_step;
          itc <= itc - 1'b1;
        end
      end
      S_DIV_Q: begin
        if (itc == '0) begin
          acc <= 33'(quo_step[29:4]);
          quo <= '0;
          src <= {quo_step[3:0], 50'b0};
          dvs <= {5'b0, sb};
          itc <= 5'd13;
        end else begin
          acc <= acc_step;
          quo <= quo_step;
          src <= src_step;
          itc <= itc - 1'b1;
        end
      end
      S_DIV_C: begin
        if (itc == '0) begin
          cosv <= dot_neg ? -$signed(cmag) : $signed(cmag);
          mcnt <= '0;
        end else begin
          acc <= acc_step;
          quo <= quo_step;
          src <= src_step;
          itc <= itc - 1'b1;
        end
      end
      S_ZMUL: begin
        prod <= mul_p;
        mcnt <= mcnt + 1'b1;
        if (mcnt == 3'd1) z <= prod[34:0];
        if (mcnt == 3'd2) z <= z + prod[34:0];
      end
      S_ZCHK: begin
        zneg       <= z[34];
        main_deg   <= 1'b0;
        main_score <= z[34] ? '0 : SCORE_ONE;
      end
      S_UMUL: begin
        u    <= mul_p[36:16];
        v    <= EXP_ONE;
        jcnt <= '0;
      end
      S_EXP: begin
        v    <= mul_p[60:30];
        jcnt <= jcnt + 1'b1;
      end
      S_VSHIFT: begin
        dvs <= 32'h4000_0000 + {1'b0, vs};
        quo <= '0;
        itc <= 5'd16;
        if (zneg) begin
          acc <= 33'(vs[30:1]);
          src <= {vs[0], 53'b0};
        end else begin
          acc <= 33'h2000_0000;
          src <= '0;
        end
      end
      S_DIV_S: begin
        if (itc == '0) begin
          main_score <= quo_step[16] ? SCORE_ONE : quo_step[15:0];
        end else begin
          acc <= acc_step;
          quo <= quo_step;
          src <= src_step;
          itc <= itc - 1'b1;
        end
      end
      S_TAIL_START: begin
        dcnt <= seen_ge_r ? HW'(cur_half - 1'b1) : HW'(seen);
      end
      S_EMIT_TAIL: begin
        if (out_load && dcnt != '0) dcnt <= dcnt - 1'b1;
      end
      default: ;
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("point taken while previous point still in progress");

  a_break_only_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !run_last) |-> (!break_found && break_index == '0))
    else $error("break reported on a non-final result");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (break_score == '0))
    else $error("degenerate result carries a score");

  a_chain_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && last_r) |=> (seen == '0 && point_count == '0 &&
                                        min_score == MIN_INIT))
    else $error("chain state not cleared after last point");

endmodule
